// ===== sv/cbwm_pkg.sv =====
package cbwm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RANGE  = 100;

  localparam int DIM_CFG_W   = 11;
  localparam int RANGE_CFG_W = 7;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int PIXEL_W     = 16;
  localparam int INDEX_W     = 10;
  localparam int BITC_W      = $clog2(PIXEL_W);

  localparam logic [DIM_CFG_W-1:0]   RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [DIM_CFG_W-1:0]   RST_IMAGE_HEIGHT = 11'd1024;
  localparam logic [RANGE_CFG_W-1:0] RST_WINDOW_RANGE = 7'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_RANGE = 2'd2;

  typedef enum logic [1:0] {
    OP_PIXEL    = 2'd0,
    OP_QUERY_XZ = 2'd1,
    OP_QUERY_YZ = 2'd2,
    OP_NOP      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    QS_OK         = 2'd0,
    QS_RANGE_BAD  = 2'd1,
    QS_INDEX_BAD  = 2'd2,
    QS_INCOMPLETE = 2'd3
  } qstat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX_WR,
    S_Q_RD,
    S_Q_LAST,
    S_DIV,
    S_OUT
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic pix_wr;
    logic q_rd;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic is_pixel;
    logic is_query;
    logic in_err;
    logic k_last;
    logic div_last;
  } sts_t;

endpackage

// ===== sv/center_band_window_mean_top.sv =====
// pixel request: accepted, then a read-modify-write of the band sums; no new request until it is done
// refused query: result offered the cycle after accept
// good query: n band-sum memory reads, one per cycle, n = window length (<= range), then the last
//   sum is accumulated and a one-bit-per-cycle divider runs before the result is offered
// one request in flight; rst restores register defaults, position and completion flag,
//   band-sum memories are not cleared
module center_band_window_mean_top
  import cbwm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RANGE  = DEF_MAX_RANGE
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             opcode,
  input  logic [PIXEL_W-1:0]     pixel_value,
  input  logic [INDEX_W-1:0]     query_index,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PIXEL_W-1:0]     mean_value,
  output logic [INDEX_W-1:0]     echo_index,
  output logic                   profile_axis,
  output logic [1:0]             status
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, memory walk, divide, hand off
  cbwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // band sums, position tracking, window accumulate and divide
  cbwm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RANGE  (MAX_RANGE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opcode       (opcode),
    .pixel_value  (pixel_value),
    .query_index  (query_index),
    .cmd          (cmd),
    .sts          (sts),
    .mean_value   (mean_value),
    .echo_index   (echo_index),
    .profile_axis (profile_axis),
    .status       (status)
  );

endmodule

// ===== sv/cbwm_ctrl.sv =====
module cbwm_ctrl
  import cbwm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_pixel) begin
            state_next = S_PIX_WR;
          end else if (sts.is_query) begin
            state_next = sts.in_err ? S_OUT : S_Q_RD;
          end
        end
      end
      S_PIX_WR: state_next = S_IDLE;
      S_Q_RD: begin
        if (sts.k_last) begin
          state_next = S_Q_LAST;
        end
      end
      S_Q_LAST: state_next = S_DIV;
      S_DIV: begin
        if (sts.div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != S_IDLE);
    out_valid    = (state == S_OUT);
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.pix_wr   = (state == S_PIX_WR);
    cmd.q_rd     = (state == S_Q_RD);
    cmd.div_step = (state == S_DIV);
  end

  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_div_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && sts.div_last) |=> out_valid)
    else $error("divide finished without a result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DIV || $past(cmd.load)))
    else $error("result appeared from nowhere");

endmodule

// ===== sv/cbwm_dp.sv =====
module cbwm_dp
  import cbwm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RANGE  = DEF_MAX_RANGE
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]             opcode,
  input  logic [PIXEL_W-1:0]     pixel_value,
  input  logic [INDEX_W-1:0]     query_index,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic [PIXEL_W-1:0]     mean_value,
  output logic [INDEX_W-1:0]     echo_index,
  output logic                   profile_axis,
  output logic [1:0]             status
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int DA  = $clog2(MAX_WIDTH + 1);
  localparam int DB  = $clog2(MAX_HEIGHT + 1);
  localparam int DW0 = (DA > DB) ? DA : DB;
  localparam int DW  = (DW0 > DIM_CFG_W) ? DW0 : DIM_CFG_W;
  localparam int RB  = $clog2(MAX_RANGE + 1);
  localparam int SW  = PIXEL_W + RB;
  localparam int TW  = SW + RB;
  localparam int CW  = 2 * RB;
  localparam int RW  = (TW > CW + PIXEL_W) ? TW : CW + PIXEL_W;

  logic [DIM_CFG_W-1:0]   cfg_w, cfg_h;
  logic [RANGE_CFG_W-1:0] cfg_r;
  logic [XW-1:0]          px;
  logic [YW-1:0]          py;
  logic                   plane_done;
  logic [PIXEL_W-1:0]     pix_val;

  logic [SW-1:0] col_mem [MAX_WIDTH];
  logic [SW-1:0] row_mem [MAX_HEIGHT];
  logic [SW-1:0] col_rd, row_rd;

  logic [DW-1:0]      k, q_hi;
  logic               q_axis;
  logic [INDEX_W-1:0] q_echo;
  qstat_t             q_stat;
  logic               rd_d;
  logic [RW-1:0]      acc, dvs;
  logic [PIXEL_W-1:0] quo;
  logic [BITC_W-1:0]  bitc;

  logic [DW-1:0] w_eff, h_eff, half_d, wc, hc;
  logic [DW-1:0] row_lo, row_hi, col_lo, col_hi;
  logic [DW-1:0] px_d, py_d, xn, yn;
  logic [DW-1:0] dim, j_d, lo, hi_raw, hi, n;
  logic [RANGE_CFG_W-1:0] two_half;
  logic [CW-1:0] count;
  logic          range_bad, axis_in;
  qstat_t        qs_in;
  logic [XW-1:0] ex, col_addr;
  logic [YW-1:0] ey, row_addr;
  logic          col_in, row_in, col_we, row_we;
  logic [SW-1:0] col_wdata, row_wdata;

  always_comb begin
    if (cfg_w == '0) w_eff = DW'(1);
    else if (DW'(cfg_w) > DW'(MAX_WIDTH)) w_eff = DW'(MAX_WIDTH);
    else w_eff = DW'(cfg_w);
    if (cfg_h == '0) h_eff = DW'(1);
    else if (DW'(cfg_h) > DW'(MAX_HEIGHT)) h_eff = DW'(MAX_HEIGHT);
    else h_eff = DW'(cfg_h);
    half_d   = DW'(cfg_r[RANGE_CFG_W-1:1]);
    two_half = {cfg_r[RANGE_CFG_W-1:1], 1'b0};
    // central row band feeds column sums, central column band feeds row sums
    hc     = h_eff >> 1;
    wc     = w_eff >> 1;
    row_lo = (hc > half_d) ? hc - half_d : '0;
    row_hi = hc + half_d;
    col_lo = (wc > half_d) ? wc - half_d : '0;
    col_hi = wc + half_d;
    px_d   = DW'(px);
    py_d   = DW'(py);
    xn     = px_d + DW'(1);
    yn     = py_d + DW'(1);
  end

  always_comb begin
    col_in    = (py_d >= row_lo) && (py_d < row_hi);
    row_in    = (px_d >= col_lo) && (px_d < col_hi);
    col_wdata = (py_d == row_lo) ? SW'(pix_val) : col_rd + SW'(pix_val);
    row_wdata = (px_d == col_lo) ? SW'(pix_val) : row_rd + SW'(pix_val);
    col_we    = cmd.pix_wr && col_in;
    row_we    = cmd.pix_wr && row_in;
    ex        = plane_done ? '0 : px;
    ey        = plane_done ? '0 : py;
    col_addr  = cmd.q_rd ? k[XW-1:0] : ex;
    row_addr  = cmd.q_rd ? k[YW-1:0] : ey;
  end

  // query decode at accept
  always_comb begin
    axis_in   = (opcode == OP_QUERY_YZ);
    dim       = axis_in ? h_eff : w_eff;
    j_d       = DW'(query_index);
    range_bad = (cfg_r < RANGE_CFG_W'(2)) || (DW'(cfg_r) > DW'(MAX_RANGE)) ||
                (DW'(cfg_r) > w_eff) || (DW'(cfg_r) > h_eff);
    if (range_bad) qs_in = QS_RANGE_BAD;
    else if (j_d >= dim) qs_in = QS_INDEX_BAD;
    else if (!plane_done) qs_in = QS_INCOMPLETE;
    else qs_in = QS_OK;
    lo     = (j_d > half_d) ? j_d - half_d : '0;
    hi_raw = j_d + half_d - DW'(1);
    hi     = (hi_raw > dim - DW'(1)) ? dim - DW'(1) : hi_raw;
    n      = hi - lo + DW'(1);
    count  = CW'(RB'(n)) * CW'(RB'(two_half));
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[px] <= col_wdata;
    end
    col_rd <= col_mem[col_addr];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[py] <= row_wdata;
    end
    row_rd <= row_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w      <= RST_IMAGE_WIDTH;
      cfg_h      <= RST_IMAGE_HEIGHT;
      cfg_r      <= RST_WINDOW_RANGE;
      px         <= '0;
      py         <= '0;
      plane_done <= 1'b0;
      rd_d       <= 1'b0;
    end else begin
      rd_d <= cmd.q_rd;
      if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
                     cfg_index == CFG_WINDOW_RANGE)) begin
        if (cfg_index == CFG_IMAGE_WIDTH) cfg_w <= cfg_data;
        if (cfg_index == CFG_IMAGE_HEIGHT) cfg_h <= cfg_data;
        if (cfg_index == CFG_WINDOW_RANGE) cfg_r <= cfg_data[RANGE_CFG_W-1:0];
        px         <= '0;
        py         <= '0;
        plane_done <= 1'b0;
      end else if (cmd.load && opcode == OP_PIXEL && plane_done) begin
        px         <= '0;
        py         <= '0;
        plane_done <= 1'b0;
      end else if (cmd.pix_wr) begin
        if (xn >= w_eff) begin
          px <= '0;
          if (yn >= h_eff) begin
            py         <= '0;
            plane_done <= 1'b1;
          end else begin
            py <= YW'(yn);
          end
        end else begin
          px <= XW'(xn);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_val <= pixel_value;
      k       <= lo;
      q_hi    <= hi;
      q_axis  <= axis_in;
      q_echo  <= query_index;
      q_stat  <= qs_in;
      acc     <= '0;
      quo     <= '0;
      dvs     <= RW'(count) << (PIXEL_W - 1);
      bitc    <= BITC_W'(PIXEL_W - 1);
    end else begin
      if (cmd.q_rd) begin
        k <= k + DW'(1);
      end
      if (rd_d) begin
        acc <= acc + RW'(q_axis ? row_rd : col_rd);
      end
      // restoring divide, one quotient bit per step
      if (cmd.div_step) begin
        if (acc >= dvs) begin
          acc       <= acc - dvs;
          quo[bitc] <= 1'b1;
        end
        dvs  <= dvs >> 1;
        bitc <= bitc - BITC_W'(1);
      end
    end
  end

  always_comb begin
    sts.is_pixel = (opcode == OP_PIXEL);
    sts.is_query = (opcode == OP_QUERY_XZ) || (opcode == OP_QUERY_YZ);
    sts.in_err   = (qs_in != QS_OK);
    sts.k_last   = (k == q_hi);
    sts.div_last = (bitc == '0);
    mean_value   = quo;
    echo_index   = q_echo;
    profile_axis = q_axis;
    status       = q_stat;
  end

  a_done_at_origin: assert property (@(posedge clk) disable iff (rst)
    plane_done |-> (px == '0 && py == '0))
    else $error("plane marked complete away from origin");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cbwm_pkg::*;

  // one profile result as it leaves the block
  typedef struct packed {
    logic [PIXEL_W-1:0] mean;
    logic [INDEX_W-1:0] index;
    logic               axis;
    qstat_t             stat;
  } profile_result_t;

  // band-sum predictor plus the queue of profile results still owed by the block
  class mean_scoreboard;
    int unsigned     width_reg, height_reg, range_reg;
    int unsigned     col_sum [DEF_MAX_WIDTH];
    int unsigned     row_sum [DEF_MAX_HEIGHT];
    int unsigned     pos_x, pos_y;
    bit              plane_done;
    profile_result_t owed_q[$];
    int              errors;
    int              pixels_seen;
    int              stat_seen[4];

    function new();
      width_reg  = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      range_reg  = RST_WINDOW_RANGE;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      return (v > top) ? top : v;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = v;
        CFG_IMAGE_HEIGHT: height_reg = v;
        CFG_WINDOW_RANGE: range_reg  = v[RANGE_CFG_W-1:0];
        default: return;
      endcase
      pos_x      = 0;
      pos_y      = 0;
      plane_done = 0;
    endfunction

    function void add_pixel(logic [PIXEL_W-1:0] v);
      int unsigned w, h, half, lo;
      w    = clamp_dim(width_reg, DEF_MAX_WIDTH);
      h    = clamp_dim(height_reg, DEF_MAX_HEIGHT);
      half = range_reg / 2;
      pixels_seen++;
      if (plane_done) begin
        plane_done = 0;
        pos_x = 0;
        pos_y = 0;
      end
      // central row band feeds the column sums
      lo = (h / 2 > half) ? h / 2 - half : 0;
      if (pos_x < DEF_MAX_WIDTH && pos_y >= lo && pos_y < h / 2 + half) begin
        if (pos_y == lo) col_sum[pos_x] = v;
        else col_sum[pos_x] += v;
      end
      // central column band feeds the row sums
      lo = (w / 2 > half) ? w / 2 - half : 0;
      if (pos_y < DEF_MAX_HEIGHT && pos_x >= lo && pos_x < w / 2 + half) begin
        if (pos_x == lo) row_sum[pos_y] = v;
        else row_sum[pos_y] += v;
      end
      pos_x++;
      if (pos_x >= w) begin
        pos_x = 0;
        pos_y++;
        if (pos_y >= h) begin
          pos_y = 0;
          plane_done = 1;
        end
      end
    endfunction

    function void note_request(opcode_t op, logic [PIXEL_W-1:0] v, logic [INDEX_W-1:0] j);
      int unsigned     w, h, r, half, dim, lo, hi;
      longint unsigned total, count;
      profile_result_t res;
      if (op == OP_PIXEL) begin
        add_pixel(v);
        return;
      end
      if (op == OP_NOP) return;
      w    = clamp_dim(width_reg, DEF_MAX_WIDTH);
      h    = clamp_dim(height_reg, DEF_MAX_HEIGHT);
      r    = range_reg;
      half = r / 2;
      dim  = (op == OP_QUERY_XZ) ? w : h;
      res.mean  = '0;
      res.index = j;
      res.axis  = (op == OP_QUERY_YZ);
      res.stat  = QS_OK;
      total     = 0;
      if (r < 2 || r > DEF_MAX_RANGE || r > w || r > h) res.stat = QS_RANGE_BAD;
      else if (j >= dim) res.stat = QS_INDEX_BAD;
      else if (!plane_done) res.stat = QS_INCOMPLETE;
      else begin
        lo = (j > half) ? j - half : 0;
        hi = j + half - 1;
        if (hi > dim - 1) hi = dim - 1;
        for (int unsigned k = lo; k <= hi; k++)
          total += (op == OP_QUERY_XZ) ? col_sum[k] : row_sum[k];
        count = longint'(hi - lo + 1) * (2 * half);
        res.mean = PIXEL_W'(total / count);
      end
      owed_q.push_back(res);
    endfunction

    function void check_result(profile_result_t got);
      profile_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = owed_q.pop_front();
      stat_seen[want.stat]++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at %0t: mean %0d/%0d index %0d/%0d axis %0d/%0d status %0d/%0d",
                   $realtime, got.mean, want.mean, got.index, want.index,
                   got.axis, want.axis, got.stat, want.stat);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             opcode = OP_NOP;
  logic [PIXEL_W-1:0]     pixel_value = '0;
  logic [INDEX_W-1:0]     query_index = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [PIXEL_W-1:0]     mean_value;
  logic [INDEX_W-1:0]     echo_index;
  logic                   profile_axis;
  logic [1:0]             status;

  mean_scoreboard sb = new();
  bit             idle_on;        // random gaps on both sides while set
  int             requests_sent;  // pixels and queries, nops not counted
  int             quiet_cycles;
  int             stall_left;

  center_band_window_mean_top u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // monitor: note accepted requests, check accepted results, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(opcode_t'(opcode), pixel_value, query_index);
      if (out_valid && !out_stall)
        sb.check_result({mean_value, echo_index, profile_axis, qstat_t'(status)});
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // receiver stall bursts start only while idle_on is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one request; valid stays high between back-to-back requests
  task automatic send_request(opcode_t op, logic [PIXEL_W-1:0] v, logic [INDEX_W-1:0] j);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    pixel_value <= v;
    query_index <= j;
    do @(posedge clk); while (in_stall);
    if (op != OP_NOP) requests_sent++;
  endtask

  // sender pauses until every owed result is back
  task automatic wait_results();
    in_valid <= 1'b0;
    // wait so the monitor has noted the last accepted request
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  // idle the block, then a pixel may still be in its write cycle
  task automatic quiesce();
    wait_results();
    repeat (20) @(posedge clk);
  endtask

  task automatic set_plane(int w, int h, int r);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    sb.write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    sb.write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_index <= CFG_WINDOW_RANGE;
    cfg_data  <= CFG_DATA_W'(r);
    @(posedge clk);
    sb.write_reg(CFG_WINDOW_RANGE, CFG_DATA_W'(r));
    cfg_we <= 1'b0;
  endtask

  // mostly in-range indexes, sometimes anything the field holds
  task automatic send_query();
    opcode_t     op;
    int unsigned dim;
    op  = $urandom_range(0, 1) ? OP_QUERY_YZ : OP_QUERY_XZ;
    dim = (op == OP_QUERY_XZ) ? sb.clamp_dim(sb.width_reg, DEF_MAX_WIDTH)
                              : sb.clamp_dim(sb.height_reg, DEF_MAX_HEIGHT);
    if ($urandom_range(0, 3) != 0) send_request(op, '0, INDEX_W'($urandom_range(0, dim - 1)));
    else send_request(op, PIXEL_W'($urandom), INDEX_W'($urandom_range(0, 1023)));
  endtask

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  // whole planes with queries mixed in, then a few queries on the finished plane
  task automatic run_planes(int planes, int tail_queries);
    int unsigned n;
    n = sb.clamp_dim(sb.width_reg, DEF_MAX_WIDTH) * sb.clamp_dim(sb.height_reg, DEF_MAX_HEIGHT);
    for (int p = 0; p < planes; p++) begin
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 11) == 0) send_query();
        if ($urandom_range(0, 40) == 0)
          send_request(OP_NOP, PIXEL_W'($urandom), INDEX_W'($urandom));
        send_request(OP_PIXEL, pick_pixel(), INDEX_W'($urandom));
      end
      // make sure the sender also waits out every owed result at times
      if ($urandom_range(0, 2) == 0) wait_results();
      for (int q = 0; q < tail_queries; q++) send_query();
    end
  endtask

  initial begin
    int w, h, r, m;
    idle_on = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults leave the plane incomplete
    send_request(OP_QUERY_XZ, '0, 10'd0);
    send_request(OP_QUERY_YZ, '0, 10'd1023);
    // tiny plane of full-scale pixels, edge indexes and one past the edge
    set_plane(4, 4, 2);
    for (int i = 0; i < 16; i++) send_request(OP_PIXEL, 16'hFFFF, '0);
    send_request(OP_QUERY_XZ, '0, 10'd0);
    send_request(OP_QUERY_XZ, '0, 10'd3);
    send_request(OP_QUERY_XZ, '0, 10'd4);
    send_request(OP_QUERY_YZ, '0, 10'd3);
    send_request(OP_NOP, 16'hFFFF, 10'd1023);
    // pixel after a complete plane restarts it
    send_request(OP_PIXEL, '0, '0);
    send_request(OP_QUERY_YZ, '0, 10'd0);
    // bad ranges: zero width, range of zero, one, too big, larger than the plane
    set_plane(0, 4, 2);
    send_request(OP_QUERY_XZ, '0, 10'd0);
    set_plane(8, 8, 0);
    send_request(OP_QUERY_YZ, '0, 10'd0);
    set_plane(8, 8, 1);
    send_request(OP_QUERY_XZ, '0, 10'd0);
    set_plane(8, 8, 127);
    send_request(OP_QUERY_XZ, '0, 10'd0);
    set_plane(8, 8, 10);
    send_request(OP_QUERY_YZ, '0, 10'd1);
    // odd range truncates the half window
    set_plane(6, 6, 5);
    run_planes(1, 4);
    // widest and tallest planes, oversized values saturate, plane not filled
    set_plane(11'd2047, 2, 2);
    send_request(OP_QUERY_XZ, '0, 10'd1023);
    send_request(OP_QUERY_YZ, '0, 10'd2);
    set_plane(2, 11'd1024, 2);
    send_request(OP_QUERY_YZ, '0, 10'd1023);
    send_request(OP_QUERY_XZ, '0, 10'd2);
    // largest window on an unfilled plane, edge and one past the edge
    set_plane(100, 100, 100);
    send_request(OP_QUERY_XZ, '0, 10'd99);
    send_request(OP_QUERY_YZ, '0, 10'd100);

    // random phases, small planes mostly, bursts of idling on and off
    while (requests_sent < 550) begin
      w = $urandom_range(2, 12);
      h = $urandom_range(2, 12);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 40);
      m = (w < h) ? w : h;
      r = (m >= 2) ? 2 * $urandom_range(1, m / 2) : 2;
      if ($urandom_range(0, 7) == 0) r = $urandom_range(0, 127);
      // last stretch runs at full rate
      idle_on = (requests_sent < 450) && ($urandom_range(0, 3) != 0);
      set_plane(w, h, r);
      run_planes($urandom_range(1, 2), $urandom_range(2, 6));
    end

    quiesce();
    repeat (150) @(posedge clk);
    $display("covered %0d pixels and results ok %0d, range bad %0d, index bad %0d,",
             sb.pixels_seen, sb.stat_seen[QS_OK], sb.stat_seen[QS_RANGE_BAD],
             sb.stat_seen[QS_INDEX_BAD]);
    $display("incomplete %0d; %0d mismatches", sb.stat_seen[QS_INCOMPLETE], sb.errors);
    if (sb.errors == 0 && sb.owed_q.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
